[design/dlpg_pkg.sv]
// Package for the DDA line point generator: widths, payload types, FSM states, commands.
package dlpg_pkg;

  localparam int COORD_W        = 6;
  localparam int GRID_SIDE_DEF  = 64;

  // Remainder arithmetic widths: 2*delta and 2*steps, remainder in [-2s, 4s).
  localparam int D2_W  = COORD_W + 2;
  localparam int S2_W  = COORD_W + 1;
  localparam int REM_W = COORD_W + 3;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } line_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic               last_point;
  } point_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;     // capture the endpoint pair
    logic step;     // compute the next point into the output registers
    logic advance;  // one point delivered, count down
  } dp_cmd_t;

  typedef struct packed {
    logic zero;     // line has no points
    logic last;     // point shown is the end point
  } dp_status_t;

endpackage

[design/dda_line_point_generator_top.sv]
// Top level of the DDA line point generator: controller plus datapath.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in      | in  | in_valid / in_stall  | in_data  (start_x, start_y, end_x, end_y)
//  out     | out | out_valid / out_stall| out_data (point_x, point_y, last_point)
//
// A line has s = max(|dx|,|dy|) points. The pair is accepted in idle, the first
// point is formed in preparation, then the per-axis remainder stepper gives one
// point per cycle while out_stall is low. A line with equal endpoints shows none.
// in_stall is high from acceptance until the end point beat is taken.
// out_stall holds the shown point; rst (synchronous) returns to idle.
module dda_line_point_generator_top
  import dlpg_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  line_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output point_out_t out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dlpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  dlpg_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

[design/dlpg_ctrl.sv]
// Controller FSM: sequences load, first-point preparation and point emission.
module dlpg_ctrl
  import dlpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_stall,
  output logic       out_valid
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = status.zero ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall && status.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PREP: begin
        cmd.step = !status.zero;
      end
      ST_EMIT: begin
        out_valid   = 1'b1;
        cmd.step    = !out_stall && !status.last;
        cmd.advance = !out_stall && !status.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[design/dlpg_datapath.sv]
// Datapath: endpoint clamp, step count, per-axis quotient/remainder stepping.
module dlpg_datapath
  import dlpg_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  input  line_in_t   in_data,
  output dp_status_t status,
  output point_out_t out_data
);

  localparam logic [COORD_W-1:0] MAX_C = COORD_W'(GRID_SIDE - 1);

  typedef struct packed {
    logic [COORD_W-1:0]      p;
    logic signed [REM_W-1:0] r;
  } axis_t;

  // One step of floor((2*i*d + s) / 2s): add 2d to the remainder, one correction.
  function automatic axis_t axis_step(input logic [COORD_W-1:0] p,
                                      input logic signed [REM_W-1:0] r,
                                      input logic signed [D2_W-1:0] d2,
                                      input logic [S2_W-1:0] s2);
    axis_t                   res;
    logic signed [REM_W-1:0] sum;
    logic signed [REM_W-1:0] s2e;
    sum   = r + {{(REM_W-D2_W){d2[D2_W-1]}}, d2};
    s2e   = $signed({{(REM_W-S2_W){1'b0}}, s2});
    res.p = p;
    res.r = sum;
    if (!d2[D2_W-1]) begin
      if (sum >= s2e) begin
        res.r = sum - s2e;
        res.p = p + COORD_W'(1);
      end
    end else begin
      if (sum < 0) begin
        res.r = sum + s2e;
        res.p = p - COORD_W'(1);
      end
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
    return (v > MAX_C) ? MAX_C : v;
  endfunction

  // Load-side arithmetic
  logic [COORD_W-1:0]        sx, sy, ex, ey;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W-1:0]        adx, ady, steps;

  always_comb begin
    sx    = clamp(in_data.start_x);
    sy    = clamp(in_data.start_y);
    ex    = clamp(in_data.end_x);
    ey    = clamp(in_data.end_y);
    dx    = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy    = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    steps = (adx > ady) ? adx : ady;
  end

  logic [COORD_W-1:0]      px, py;
  logic signed [REM_W-1:0] rx, ry;
  logic signed [D2_W-1:0]  dx2, dy2;
  logic [S2_W-1:0]         s2;
  logic [COORD_W-1:0]      left;
  axis_t                   nx, ny;

  assign nx = axis_step(px, rx, dx2, s2);
  assign ny = axis_step(py, ry, dy2, s2);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (cmd.load) begin
      left <= steps;
    end else if (cmd.advance) begin
      left <= left - COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px  <= sx;
      py  <= sy;
      rx  <= $signed({{(REM_W-COORD_W){1'b0}}, steps});
      ry  <= $signed({{(REM_W-COORD_W){1'b0}}, steps});
      dx2 <= {dx, 1'b0};
      dy2 <= {dy, 1'b0};
      s2  <= {steps, 1'b0};
    end else if (cmd.step) begin
      px <= nx.p;
      rx <= nx.r;
      py <= ny.p;
      ry <= ny.r;
    end
  end

  assign status.zero = (left == '0);
  assign status.last = (left == COORD_W'(1));

  assign out_data.point_x    = px;
  assign out_data.point_y    = py;
  assign out_data.last_point = status.last;

endmodule

[design/dlpg_checker.sv]
// Port-level checker for the DDA line point generator, bound to the top level.
module dlpg_checker
  import dlpg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input point_out_t out_data
);

  // No new pair is taken while a point is on the output.
  a_busy_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a point is pending");

  // First point never shows in the cycle after a pair is taken.
  a_prep_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("point shown without preparation cycle");

  // Points of a line follow back to back until the end point.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last_point) |=> out_valid)
    else $error("run ended before the end point");

  // After the end point beat the output goes quiet.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.last_point) |=> !out_valid)
    else $error("point shown after the end point");

  // A stalled point holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output changed");

endmodule

bind dda_line_point_generator_top dlpg_checker u_dlpg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
